[rtl/cse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity engine package
// Shared payload types, controller/datapath interface types and widths.
// ----------------------------------------------------------------------------
package cse_pkg;

   localparam int ELEMENT_W            = 16;
   localparam int ELEMENT_BITS_DEFAULT = 16;
   localparam int PROD_W               = 2 * ELEMENT_W;
   localparam int DOT_W                = 42;
   localparam int ENERGY_W             = 41;
   localparam int SIM_W                = 16;
   localparam int QUOT_W               = SIM_W - 1;

   // Square root: two radicand bits per step.
   localparam int ROOT_W     = (ENERGY_W + 1) / 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int RADICAND_W = 2 * ROOT_W;

   // Division: divisor is twice the root product.
   localparam int NORM_W    = 2 * ROOT_W;
   localparam int DIVISOR_W = NORM_W + 1;
   localparam int DIVREM_W  = DIVISOR_W + 1;
   localparam int DIV_STEPS = QUOT_W;

   localparam int STEP_W = $clog2(SQRT_STEPS);

   localparam logic [QUOT_W-1:0] SIM_MAX = {QUOT_W{1'b1}};

   typedef struct packed {
      logic signed [ELEMENT_W-1:0] embed_value;
      logic signed [ELEMENT_W-1:0] proto_value;
      logic                        final_element;
   } cse_req_type;

   typedef struct packed {
      logic signed [SIM_W-1:0] similarity;
      logic                    zero_norm;
   } cse_rsp_type;

   typedef struct packed {
      logic accept;
      logic latch;
      logic sqrt_step;
      logic mult;
      logic div_load;
      logic div_check;
      logic div_step;
      logic write;
   } cse_cmd_type;

   typedef struct packed {
      logic energy_zero;
      logic overflow;
      logic slot_free;
   } cse_status_type;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_LATCH,
      ST_SQRT,
      ST_MULT,
      ST_DIV_LOAD,
      ST_DIV_CHECK,
      ST_DIVIDE,
      ST_WRITE
   } cse_state_type;

endpackage
`default_nettype wire

[rtl/cosine_similarity_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity engine
// Accumulates dot product and energies of two vectors and emits their cosine.
// ----------------------------------------------------------------------------
// Throughput: one element pair per cycle while a vector streams in; after the
// final pair no new pair is taken until the 21-step square root and the
// 15-step restoring divider have run and the result has been written.
// Result: drain, latch, square roots, root product, divider load, saturation
// check, divide, write; saturation skips the divide, zero energy skips to write.
// Reset (synchronous) clears the accumulators and control state at once.
// ----------------------------------------------------------------------------
module cosine_similarity_engine #(
   parameter int ELEMENT_BITS = cse_pkg::ELEMENT_BITS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  cse_pkg::cse_req_type  req_payload,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output cse_pkg::cse_rsp_type  rsp_payload
);
   import cse_pkg::*;

   // The controller and the datapath talk only through these two groups.
   cse_cmd_type    cmd;
   cse_status_type status;

   // The controller decides when a transaction is taken on the request side
   // and walks the end-of-vector sequence: drain the product stage, latch and
   // clear the accumulators, run both square roots side by side, form the
   // root product, test for saturation and divide one quotient bit a cycle.
   cse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_payload.final_element),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // The datapath holds the output register, so a finished result waits there
   // while the next vector is already being accumulated.
   cse_datapath #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A zero-energy result always carries a similarity of zero.
   a_zero_sim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.zero_norm |-> rsp_payload.similarity == '0)
      else $error("zero energy result with nonzero similarity");

   // Saturation keeps the similarity symmetric around zero.
   a_sym_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.similarity != {1'b1, {(SIM_W-1){1'b0}}})
      else $error("similarity outside symmetric range");

   // Once the final pair of a vector is taken, no new transaction follows
   // until the result has been formed.
   a_final_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.final_element |=> req_stall)
      else $error("request taken right after final element");

endmodule
`default_nettype wire

[rtl/cse_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor square root, one root bit per step.
// ----------------------------------------------------------------------------
module cse_sqrt (
   input  wire                           clock,
   input  wire                           load,
   input  wire                           step,
   input  wire  [cse_pkg::ENERGY_W-1:0]  value,
   output logic [cse_pkg::ROOT_W-1:0]    root
);
   import cse_pkg::*;

   logic [RADICAND_W-1:0] x_ff, x_in;
   logic [ROOT_W:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [ROOT_W+2:0]     rem_shift;
   logic [ROOT_W+2:0]     trial;
   logic [ROOT_W+2:0]     diff;

   always_comb begin
      rem_shift = {rem_ff, x_ff[RADICAND_W-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      diff      = rem_shift - trial;
      x_in      = x_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (load) begin
         x_in    = {{(RADICAND_W-ENERGY_W){1'b0}}, value};
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         x_in = {x_ff[RADICAND_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = diff[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule
`default_nettype wire

[rtl/cse_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity controller
// Sequences accumulation, square roots, the divide and the result write.
// ----------------------------------------------------------------------------
module cse_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_final,
   input  cse_pkg::cse_status_type  status,
   output cse_pkg::cse_cmd_type     cmd,
   output logic                     req_stall
);
   import cse_pkg::*;

   cse_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_ACCUM: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && req_final) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            step_in   = '0;
            state_in  = status.energy_zero ? ST_WRITE : ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_MULT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_CHECK;
         end
         ST_DIV_CHECK: begin
            cmd.div_check = 1'b1;
            state_in      = status.overflow ? ST_WRITE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_WRITE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (status.slot_free) begin
               cmd.write = 1'b1;
               state_in  = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // The result register is only written when it can take a new result.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> status.slot_free)
      else $error("result written while output slot occupied");

   // A started vector end always passes through the latch step.
   a_drain_latch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |=> state_ff == ST_LATCH)
      else $error("drain not followed by latch");

endmodule
`default_nettype wire

[rtl/cse_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity datapath
// Accumulators, square root units, root product, divider and result register.
// ----------------------------------------------------------------------------
module cse_datapath #(
   parameter int ELEMENT_BITS = cse_pkg::ELEMENT_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  cse_pkg::cse_req_type     req_payload,
   input  cse_pkg::cse_cmd_type     cmd,
   output cse_pkg::cse_status_type  status,
   input  wire                      rsp_stall,
   output logic                     rsp_valid,
   output cse_pkg::cse_rsp_type     rsp_payload
);
   import cse_pkg::*;

   localparam int EXT_SHIFT = ELEMENT_W - ELEMENT_BITS;

   logic signed [ELEMENT_W-1:0] embed_ext, proto_ext;
   logic        [ELEMENT_W-1:0] embed_sh, proto_sh;

   logic signed [PROD_W-1:0] dot_prod_ff, embed_sq_ff, proto_sq_ff;
   logic                     prod_valid_ff;

   logic [DOT_W-1:0]    dot_ff, dot_in;
   logic [ENERGY_W-1:0] embed_energy_ff, embed_energy_in;
   logic [ENERGY_W-1:0] proto_energy_ff, proto_energy_in;

   logic [ROOT_W-1:0]    embed_root, proto_root;
   logic                 neg_ff;
   logic [DOT_W-1:0]     mag_ff;
   logic                 zero_ff;
   logic [NORM_W-1:0]    norm_ff;
   logic [DIVISOR_W-1:0] divisor;
   logic [DIVREM_W-1:0]  rem_ff, rem_in, rem_shift, rem_diff;
   logic [QUOT_W-1:0]    low_ff, low_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic                 sat_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   cse_rsp_type          rsp_ff, rsp_in;
   logic [QUOT_W-1:0]    quot_mag;

   // Only the low element bits carry data; sign-extend from the top one.
   always_comb begin
      embed_sh  = req_payload.embed_value << EXT_SHIFT;
      proto_sh  = req_payload.proto_value << EXT_SHIFT;
      embed_ext = $signed(embed_sh) >>> EXT_SHIFT;
      proto_ext = $signed(proto_sh) >>> EXT_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.accept;
      end
      if (cmd.accept) begin
         dot_prod_ff <= embed_ext * proto_ext;
         embed_sq_ff <= embed_ext * embed_ext;
         proto_sq_ff <= proto_ext * proto_ext;
      end
   end

   always_comb begin
      dot_in          = dot_ff;
      embed_energy_in = embed_energy_ff;
      proto_energy_in = proto_energy_ff;
      if (cmd.latch) begin
         dot_in          = '0;
         embed_energy_in = '0;
         proto_energy_in = '0;
      end else if (prod_valid_ff) begin
         dot_in = dot_ff + {{(DOT_W-PROD_W){dot_prod_ff[PROD_W-1]}}, dot_prod_ff};
         embed_energy_in = embed_energy_ff
                         + {{(ENERGY_W-PROD_W){1'b0}}, embed_sq_ff};
         proto_energy_in = proto_energy_ff
                         + {{(ENERGY_W-PROD_W){1'b0}}, proto_sq_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff          <= '0;
         embed_energy_ff <= '0;
         proto_energy_ff <= '0;
      end else begin
         dot_ff          <= dot_in;
         embed_energy_ff <= embed_energy_in;
         proto_energy_ff <= proto_energy_in;
      end
   end

   cse_sqrt u_embed_sqrt (
      .clock (clock),
      .load  (cmd.latch),
      .step  (cmd.sqrt_step),
      .value (embed_energy_ff),
      .root  (embed_root)
   );

   cse_sqrt u_proto_sqrt (
      .clock (clock),
      .load  (cmd.latch),
      .step  (cmd.sqrt_step),
      .value (proto_energy_ff),
      .root  (proto_root)
   );

   assign divisor = {norm_ff, 1'b0};

   always_comb begin
      rem_shift = {rem_ff[DIVREM_W-2:0], low_ff[QUOT_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      rem_in    = rem_ff;
      low_in    = low_ff;
      quot_in   = quot_ff;
      if (cmd.div_load) begin
         // Upper part of (magnitude * 65536 + norm) over 2^15, low bits of norm.
         rem_in  = {{(DIVREM_W-DOT_W-1){1'b0}}, mag_ff, 1'b0}
                 + {{(DIVREM_W-NORM_W+QUOT_W){1'b0}}, norm_ff[NORM_W-1:QUOT_W]};
         low_in  = norm_ff[QUOT_W-1:0];
         quot_in = '0;
      end else if (cmd.div_step) begin
         low_in = {low_ff[QUOT_W-2:0], 1'b0};
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in  = rem_diff;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         neg_ff  <= dot_ff[DOT_W-1];
         mag_ff  <= dot_ff[DOT_W-1] ? (~dot_ff + 1'b1) : dot_ff;
         zero_ff <= status.energy_zero;
      end
      if (cmd.mult) begin
         norm_ff <= embed_root * proto_root;
      end
      if (cmd.div_load) begin
         sat_ff <= 1'b0;
      end else if (cmd.div_check) begin
         sat_ff <= status.overflow;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   always_comb begin
      status.energy_zero = (embed_energy_ff == '0) || (proto_energy_ff == '0);
      status.overflow    = rem_ff >= {1'b0, divisor};
      status.slot_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      quot_mag     = sat_ff ? SIM_MAX : quot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
         if (zero_ff) begin
            rsp_in.similarity = '0;
            rsp_in.zero_norm  = 1'b1;
         end else begin
            rsp_in.similarity = neg_ff ? -$signed({1'b0, quot_mag})
                                       :  $signed({1'b0, quot_mag});
            rsp_in.zero_norm  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Accumulators are empty right after a vector end is latched.
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> (dot_ff == '0) && (embed_energy_ff == '0))
      else $error("accumulators not cleared at vector end");

endmodule
`default_nettype wire

[test/tb_cosine_similarity_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity engine testbench
// Streams embedding/prototype element pairs into the engine through bursty
// traffic. A local integer model predicts every similarity result, and the
// monitor checks each returned transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_engine;
   import cse_pkg::*;

   // Element width the engine is built with. The predictor sign-extends
   // from the same bit.
   localparam int ELEMENT_BITS = ELEMENT_BITS_DEFAULT;

   localparam logic [63:0] SIM_LIMIT = 64'(SIM_MAX);

   // Input volume and the run's time budget.
   localparam int  PAIR_TARGET  = 1550;
   localparam int  DRAIN_CYCLES = 120;
   localparam real RUN_LIMIT_NS = 1_000_000.0;

   // The receiver holds off once for a long stretch so that the engine backs
   // up and stalls its input while the sender keeps offering pairs.
   localparam int HOLD_START  = 3000;
   localparam int HOLD_CYCLES = 800;

   typedef enum int {
      STYLE_RANDOM,
      STYLE_SMALL,
      STYLE_MATCHED,
      STYLE_OPPOSED,
      STYLE_NEAR,
      STYLE_ZERO_EMBED,
      STYLE_ZERO_PROTO,
      STYLE_SPARSE,
      STYLE_EXTREME
   } vector_style_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // One queued pair. When idle_first is set, the sender holds the pair
   // back until every earlier result has come out of the engine.
   typedef struct {
      cse_req_type pair;
      bit          idle_first;
   } queued_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cse_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cse_rsp_type rsp_payload;

   queued_pair_type queued_pairs[$];
   cse_rsp_type     expected_similarities[$];
   int              pairs_queued = 0;
   int              error_count = 0;

   // Snapshot of "no similarity outstanding", taken on the falling edge so
   // that the sender reads a settled value at the rising edge.
   bit results_settled = 1'b1;

   // Model accumulators, widths as in the engine.
   logic [DOT_W-1:0]    dot_acc = '0;
   logic [ENERGY_W-1:0] embed_energy_acc = '0;
   logic [ENERGY_W-1:0] proto_energy_acc = '0;

   // Sender burst shaping.
   int              burst_left = 1;
   int              gap_left = 0;
   queued_pair_type next_pair;

   // Receiver stall shaping.
   int             recv_cycle = 0;
   int             hold_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic           stall_next;

   cse_rsp_type oldest_expected;

   cosine_similarity_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Integer model of the engine.
   // ------------------------------------------------------------------------

   // Only the low ELEMENT_BITS bits of an element count, sign-extended.
   function automatic longint element_signed(input logic [ELEMENT_W-1:0] raw);
      logic [63:0] wide;
      wide = {{(64 - ELEMENT_W){1'b0}}, raw} << (64 - ELEMENT_BITS);
      return $signed(wide) >>> (64 - ELEMENT_BITS);
   endfunction

   // Floor of the square root, two radicand bits per iteration.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_mask;
      rem = value;
      root = '0;
      bit_mask = 64'd1 << 62;
      while (bit_mask > rem)
         bit_mask = bit_mask >> 2;
      while (bit_mask != 0) begin
         if (rem >= root + bit_mask) begin
            rem = rem - (root + bit_mask);
            root = (root >> 1) + bit_mask;
         end else begin
            root = root >> 1;
         end
         bit_mask = bit_mask >> 2;
      end
      return root;
   endfunction

   // Folds one accepted pair into the accumulators. On the final pair of a
   // vector it queues the predicted similarity and clears the accumulators.
   task automatic fold_element_pair(input cse_req_type pair);
      longint             e_val;
      longint             p_val;
      logic [63:0]        dot_term;
      logic [63:0]        embed_term;
      logic [63:0]        proto_term;
      logic [DOT_W-1:0]   dot_mag;
      logic [63:0]        magnitude;
      logic [63:0]        root_prod;
      logic [63:0]        quotient;
      logic               negative;
      cse_rsp_type        predicted;
      e_val = element_signed(pair.embed_value);
      p_val = element_signed(pair.proto_value);
      dot_term = e_val * p_val;
      embed_term = e_val * e_val;
      proto_term = p_val * p_val;
      dot_acc = dot_acc + dot_term[DOT_W-1:0];
      embed_energy_acc = embed_energy_acc + embed_term[ENERGY_W-1:0];
      proto_energy_acc = proto_energy_acc + proto_term[ENERGY_W-1:0];
      if (!pair.final_element)
         return;
      if (embed_energy_acc == 0 || proto_energy_acc == 0) begin
         // Either vector has no energy: the cosine is undefined, so the
         // engine reports zero and raises the flag.
         predicted.similarity = '0;
         predicted.zero_norm = 1'b1;
      end else begin
         negative = dot_acc[DOT_W-1];
         dot_mag = negative ? (~dot_acc + 1'b1) : dot_acc;
         magnitude = 64'(dot_mag);
         root_prod = floor_sqrt(embed_energy_acc) * floor_sqrt(proto_energy_acc);
         // Round to nearest, halves away from zero, then saturate. The
         // floored roots can push the quotient past full scale.
         quotient = (magnitude * 64'd65536 + root_prod) / (root_prod * 64'd2);
         if (quotient > SIM_LIMIT)
            quotient = SIM_LIMIT;
         predicted.similarity = negative ? -quotient[SIM_W-1:0] : quotient[SIM_W-1:0];
         predicted.zero_norm = 1'b0;
      end
      expected_similarities.push_back(predicted);
      dot_acc = '0;
      embed_energy_acc = '0;
      proto_energy_acc = '0;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building.
   // ------------------------------------------------------------------------

   task automatic queue_pair(input logic [ELEMENT_W-1:0] embed,
                             input logic [ELEMENT_W-1:0] proto,
                             input bit last, input bit idle_first);
      queued_pair_type entry;
      entry.pair.embed_value = embed;
      entry.pair.proto_value = proto;
      entry.pair.final_element = last;
      entry.idle_first = idle_first;
      queued_pairs.push_back(entry);
      pairs_queued++;
   endtask

   // Picks one of the values at the corners of the element range.
   function automatic logic [ELEMENT_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0001;
         default: return 16'h0000;
      endcase
   endfunction

   // Queues one whole vector whose content follows a randomly chosen style,
   // so that near-parallel, opposed, orthogonal-ish and zero-energy vectors
   // all occur alongside plain random ones.
   task automatic queue_vector(input int length, input bit idle_first);
      vector_style_type     style;
      logic [ELEMENT_W-1:0] embed;
      logic [ELEMENT_W-1:0] proto;
      int                   k;
      style = vector_style_type'($urandom_range(STYLE_RANDOM, STYLE_EXTREME));
      for (k = 0; k < length; k++) begin
         embed = 16'($urandom);
         proto = 16'($urandom);
         case (style)
            STYLE_SMALL: begin
               embed = 16'($urandom_range(0, 32)) - 16'd16;
               proto = 16'($urandom_range(0, 32)) - 16'd16;
            end
            STYLE_MATCHED:    proto = embed;
            STYLE_OPPOSED:    proto = -embed;
            STYLE_NEAR:       proto = embed + 16'($urandom_range(0, 63)) - 16'd32;
            STYLE_ZERO_EMBED: embed = '0;
            STYLE_ZERO_PROTO: proto = '0;
            STYLE_SPARSE: begin
               if ($urandom_range(0, 3) != 0)
                  embed = '0;
               if ($urandom_range(0, 3) != 0)
                  proto = '0;
            end
            STYLE_EXTREME: begin
               embed = corner_value();
               proto = corner_value();
            end
            default: ;
         endcase
         queue_pair(embed, proto, k == length - 1, idle_first && k == 0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Sender. Each rising edge it first folds an accepted transaction into the
   // model, then decides what to offer next. A stalled pair is held as it is;
   // a free slot gets the next queued pair unless the burst is in a gap.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            fold_element_pair(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (queued_pairs.size() != 0 &&
                         (!queued_pairs[0].idle_first || (!req_valid && results_settled))) begin
               next_pair = queued_pairs.pop_front();
               req_payload <= next_pair.pair;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  // Start a new burst. Some bursts are long and gap-free so
                  // the engine also sees stretches of back-to-back traffic.
                  if ($urandom_range(0, 4) == 0) begin
                     burst_left <= $urandom_range(40, 200);
                     gap_left <= 0;
                  end else begin
                     burst_left <= $urandom_range(1, 16);
                     gap_left <= $urandom_range(0, 6);
                  end
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      results_settled = (expected_similarities.size() == 0);
   end

   // ------------------------------------------------------------------------
   // Receiver. The stall pattern switches between random modes; one long
   // hold-off, counted here, lets the engine fill and push back on the sender.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         recv_cycle <= recv_cycle + 1;
         if (recv_cycle % 97 == 0)
            stall_mode <= stall_mode_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
         if (recv_cycle == HOLD_START)
            hold_left <= HOLD_CYCLES;
         else if (hold_left != 0)
            hold_left <= hold_left - 1;
         case (stall_mode)
            STALL_RANDOM:   stall_next = ($urandom_range(0, 1) == 0);
            STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: stall_next = (recv_cycle % 5 < 3);
            default:        stall_next = 1'b0;
         endcase
         if (recv_cycle == HOLD_START || hold_left > 1)
            stall_next = 1'b1;
         rsp_stall <= stall_next;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Every accepted result transaction is matched against the
   // oldest prediction, field by field.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_similarities.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: similarity %0d zero_norm %0b",
                                      rsp_payload.similarity, rsp_payload.zero_norm));
         end else begin
            oldest_expected = expected_similarities.pop_front();
            if (rsp_payload.similarity !== oldest_expected.similarity)
               report_mismatch($sformatf("similarity %0d, expected %0d",
                                         rsp_payload.similarity, oldest_expected.similarity));
            if (rsp_payload.zero_norm !== oldest_expected.zero_norm)
               report_mismatch($sformatf("zero_norm %0b, expected %0b",
                                         rsp_payload.zero_norm, oldest_expected.zero_norm));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed vectors, random vectors, drain, verdict.
   // ------------------------------------------------------------------------
   initial begin
      int roll;
      int length;

      // Directed part. Single-pair vectors at the range corners saturate to
      // full scale in either direction.
      queue_pair(16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
      queue_pair(16'h8000, 16'h8000, 1'b1, 1'b0);
      queue_pair(16'h8000, 16'h7FFF, 1'b1, 1'b0);
      queue_pair(16'h7FFF, 16'h8000, 1'b1, 1'b0);
      // Zero energy on one side or both.
      queue_pair(16'h0000, 16'h0000, 1'b1, 1'b0);
      queue_pair(16'h0000, 16'h8000, 1'b1, 1'b0);
      queue_pair(16'h7FFF, 16'h0000, 1'b1, 1'b0);
      queue_pair(16'h0000, 16'h0003, 1'b0, 1'b0);
      queue_pair(16'h0000, 16'hFFFC, 1'b1, 1'b0);
      // Orthogonal vectors give a zero dot product with nonzero energies.
      queue_pair(16'h0001, 16'h0001, 1'b0, 1'b0);
      queue_pair(16'h0001, 16'hFFFF, 1'b1, 1'b0);
      // Alternating bit patterns on both elements.
      queue_pair(16'h5555, 16'hAAAA, 1'b0, 1'b0);
      queue_pair(16'hAAAA, 16'h5555, 1'b1, 1'b0);
      // Small mixed vectors with ordinary fractional results.
      queue_pair(16'd100, -16'sd200, 1'b0, 1'b0);
      queue_pair(16'd300, 16'd50, 1'b0, 1'b0);
      queue_pair(-16'sd7, 16'd9, 1'b1, 1'b0);
      queue_pair(16'd1, 16'd2, 1'b1, 1'b0);
      queue_pair(16'd3, 16'd4, 1'b0, 1'b0);
      queue_pair(16'd4, 16'd3, 1'b1, 1'b0);

      // Random part. The first random vector waits for the directed results
      // to drain; a few later ones do the same. Most vectors are short, some run
      // up to 130 pairs.
      queue_vector($urandom_range(1, 8), 1'b1);
      while (pairs_queued < PAIR_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 80)
            length = $urandom_range(1, 8);
         else if (roll < 95)
            length = $urandom_range(9, 40);
         else
            length = $urandom_range(41, 130);
         queue_vector(length, $urandom_range(0, 19) == 0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait until the last pair is taken, then until every prediction has
      // been matched, then a margin for stray results.
      do
         @(negedge clock);
      while (queued_pairs.size() != 0 || req_valid);
      do
         @(negedge clock);
      while (expected_similarities.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_cosine_similarity_engine: clean");
      else
         $display("tb_cosine_similarity_engine: errors");
      $finish;
   end

   // Watchdog against a hung engine or a lost result.
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_cosine_similarity_engine: errors");
      $finish;
   end

endmodule
